// ----- rtl/core/tftprr_pkg.sv -----
package tftprr_pkg;

  // payload bytes in a full DATA block
  localparam int unsigned BLOCK_BYTES = 512;

  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [15:0] HDR_BYTES = 16'd4;
  localparam logic [15:0] MIN_LEN   = 16'd2;
  localparam logic [15:0] MAX_LEN   = HDR_BYTES + 16'(BLOCK_BYTES);
  localparam logic [15:0] TICK_SAT  = 16'hffff;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PACKET = 2'd1,
    CMD_TICK = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_BYTES = 2'd0,
    REG_REQ_WAIT = 2'd1,
    REG_DATA_WAIT = 2'd2,
    REG_REQ_TRIES = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FAIL_NONE = 3'd0,
    FAIL_SERVER = 3'd1,
    FAIL_TOO_BIG = 3'd2,
    FAIL_NO_RESP = 3'd3,
    FAIL_ABORT = 3'd4
  } fail_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_REQ = 3'b010,
    PH_XFER = 3'b100
  } phase_t;

  typedef struct packed {
    logic [31:0] loaded_bytes;
    logic [15:0] error_number;
    logic [2:0]  fail_reason;
    logic        failed;
    logic        finished;
    logic [9:0]  write_length;
    logic [31:0] write_offset;
    logic        write_enable;
    logic [15:0] ack_block;
    logic        send_ack;
    logic        send_request;
  } result_t;

endpackage

// ----- rtl/core/tftp_read_receiver_top.sv -----
// TFTP read receiver, octet mode. Each input beat is one event (start, packet
// header received, timer tick or user abort) and yields exactly one result
// beat: resend the RRQ, send an ACK for ack_block, write a payload of
// write_length bytes at write_offset, or report finished / failed with a
// reason. One event is taken per cycle back to back while out_tready is high;
// a beat is held in the input register, then the state and result registers
// update together. The rate is bounded only by the combinational state update
// logic (33-bit size check and block compares). The output register lets a new
// beat be taken into an empty input register while a finished
// result still waits. Configuration writes are accepted at any time but must
// only be issued while no event is in flight.
module tftp_read_receiver_top
  import tftprr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // event beats
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,  // [1:0] command
  // [15:0] opcode, [31:16] block_or_error, [47:32] packet_length,
  // [48] from_server, [55:49] zero
  input  logic [55:0]          in_tdata,
  // result beats
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [0] send_request, [1] send_ack, [17:2] ack_block, [18] write_enable,
  // [50:19] write_offset, [60:51] write_length, [61] finished, [62] failed,
  // [65:63] fail_reason, [81:66] error_number, [113:82] loaded_bytes,
  // [119:114] zero
  output logic [119:0]         out_tdata
);

  // configuration
  logic [31:0] max_bytes_r;
  logic [15:0] req_wait_r;
  logic [15:0] data_wait_r;
  logic [7:0]  req_tries_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= 32'hffff_ffff;
      req_wait_r  <= 16'd2;
      data_wait_r <= 16'd10;
      req_tries_r <= 8'd10;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_BYTES: max_bytes_r <= cfg_data;
        REG_REQ_WAIT:  req_wait_r  <= cfg_data[15:0];
        REG_DATA_WAIT: data_wait_r <= cfg_data[15:0];
        REG_REQ_TRIES: req_tries_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic        in_vld_r;
  cmd_t        cmd_r;
  logic [15:0] opcode_r;
  logic [15:0] blk_r;
  logic [15:0] len_r;
  logic        from_srv_r;

  logic        out_vld_r;
  result_t     res_r;
  logic        advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r      <= cmd_t'(in_tuser);
      opcode_r   <= in_tdata[15:0];
      blk_r      <= in_tdata[31:16];
      len_r      <= in_tdata[47:32];
      from_srv_r <= in_tdata[48];
    end
  end

  // transfer state
  phase_t      phase_r, phase_nxt;
  logic [15:0] exp_blk_r, exp_blk_nxt;
  logic [31:0] loaded_r, loaded_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  req_sent_r, req_sent_nxt;
  result_t     res_nxt;

  logic        busy;
  logic        pkt_ok;
  logic [15:0] payload;
  logic [32:0] total;
  logic [15:0] last_blk;
  logic [15:0] ticks_inc;
  logic        take;

  always_comb begin
    busy      = (phase_r == PH_REQ) || (phase_r == PH_XFER);
    pkt_ok    = from_srv_r && (len_r >= MIN_LEN) && (len_r <= MAX_LEN);
    payload   = len_r - HDR_BYTES;
    total     = {1'b0, loaded_r} + {17'd0, payload};
    last_blk  = exp_blk_r - 16'd1;
    ticks_inc = (ticks_r == TICK_SAT) ? ticks_r : ticks_r + 16'd1;
    take      = 1'b0;

    phase_nxt    = phase_r;
    exp_blk_nxt  = exp_blk_r;
    loaded_nxt   = loaded_r;
    ticks_nxt    = ticks_r;
    req_sent_nxt = req_sent_r;
    res_nxt      = '0;

    case (cmd_r)
      CMD_START: begin
        phase_nxt    = PH_REQ;
        exp_blk_nxt  = 16'd1;
        loaded_nxt   = '0;
        ticks_nxt    = '0;
        req_sent_nxt = 8'd1;
        res_nxt.send_request = 1'b1;
      end
      CMD_PACKET: begin
        if (busy && pkt_ok) begin
          if (opcode_r == OP_ERROR) begin
            res_nxt.error_number = (len_r >= HDR_BYTES) ? blk_r : 16'd0;
            res_nxt.failed       = 1'b1;
            res_nxt.fail_reason  = FAIL_SERVER;
            phase_nxt            = PH_IDLE;
          end else if (opcode_r == OP_DATA && len_r >= HDR_BYTES) begin
            if (phase_r == PH_REQ) begin
              take = (blk_r == 16'd1);
            end else if (blk_r == exp_blk_r) begin
              take = 1'b1;
            end else if (blk_r == last_blk) begin
              res_nxt.send_ack  = 1'b1;
              res_nxt.ack_block = last_blk;
              ticks_nxt         = '0;
            end
          end
        end
      end
      CMD_TICK: begin
        if (busy) begin
          ticks_nxt = ticks_inc;
          if (phase_r == PH_REQ) begin
            if (ticks_inc >= req_wait_r) begin
              if (req_sent_r >= req_tries_r) begin
                res_nxt.failed      = 1'b1;
                res_nxt.fail_reason = FAIL_NO_RESP;
                phase_nxt           = PH_IDLE;
              end else begin
                res_nxt.send_request = 1'b1;
                req_sent_nxt         = req_sent_r + 8'd1;
                ticks_nxt            = '0;
              end
            end
          end else if (ticks_inc >= data_wait_r) begin
            res_nxt.failed      = 1'b1;
            res_nxt.fail_reason = FAIL_NO_RESP;
            phase_nxt           = PH_IDLE;
          end
        end
      end
      CMD_ABORT: begin
        if (busy) begin
          res_nxt.failed      = 1'b1;
          res_nxt.fail_reason = FAIL_ABORT;
          phase_nxt           = PH_IDLE;
        end
      end
      default: ;
    endcase

    // in-order block accepted: size check, store, ACK
    if (take) begin
      if (total > {1'b0, max_bytes_r}) begin
        res_nxt.failed      = 1'b1;
        res_nxt.fail_reason = FAIL_TOO_BIG;
        phase_nxt           = PH_IDLE;
      end else begin
        if (payload != 16'd0) begin
          res_nxt.write_enable = 1'b1;
          res_nxt.write_offset = loaded_r;
          res_nxt.write_length = payload[9:0];
        end
        loaded_nxt        = total[31:0];
        res_nxt.send_ack  = 1'b1;
        res_nxt.ack_block = exp_blk_r;
        exp_blk_nxt       = exp_blk_r + 16'd1;
        ticks_nxt         = '0;
        if (payload < 16'(BLOCK_BYTES)) begin
          res_nxt.finished = 1'b1;
          phase_nxt        = PH_IDLE;
        end else begin
          phase_nxt = PH_XFER;
        end
      end
    end

    res_nxt.loaded_bytes = loaded_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      exp_blk_r  <= 16'd1;
      loaded_r   <= '0;
      ticks_r    <= '0;
      req_sent_r <= '0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      exp_blk_r  <= exp_blk_nxt;
      loaded_r   <= loaded_nxt;
      ticks_r    <= ticks_nxt;
      req_sent_r <= req_sent_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, res_r};

  // checks
  a_fail_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.failed |-> !res_r.send_ack && !res_r.write_enable)
    else $error("failure result carries an ACK or a write");

  a_write_acked: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.write_enable |-> res_r.send_ack && !res_r.send_request)
    else $error("payload write without ACK");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.finished || res_r.failed) |-> phase_r == PH_IDLE)
    else $error("transfer ended but phase not idle");

  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.failed == (res_r.fail_reason != FAIL_NONE))
    else $error("fail flag and reason disagree");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !in_vld_r)
    else $error("pipeline not empty after reset");

endmodule
